/* src/ifsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsf_pkg
// Shared types and constants of the information frame stuffing framer.
// ----------------------------------------------------------------------------
package ifsf_pkg;

    // line codes
    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] STUFF_MASK = 8'h20;
    localparam logic [7:0] CTRL_SEQ1  = 8'h40;
    localparam logic [7:0] CTRL_SEQ0  = 8'h00;

    // most line bytes one payload byte can cause
    localparam int unsigned MAX_BURST = 9;
    localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);
    localparam int unsigned SLOT_W    = $clog2(MAX_BURST);

    // configuration register map
    localparam int unsigned    PADDR_W           = 2;
    localparam logic [PADDR_W-1:0] ADDR_STATION  = 2'd0;
    localparam logic [7:0]     STATION_RESET     = 8'd3;

    // line bytes caused by one payload byte
    typedef struct packed {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [BURST_W-1:0]        count;
        logic                      closes;
    } burst_t;

    // byte must be escaped on the line
    function automatic logic needs_stuff(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

endpackage
`default_nettype wire

/* src/ifsf_burst.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsf_burst
// Packs the header, stuffed payload byte, stuffed BCC2 and closing flag that
// one payload byte causes into a burst, and gives the next frame state.
// ----------------------------------------------------------------------------
module ifsf_burst
(
    input  wire logic [7:0]      station_address,
    input  wire logic            inside_frame,
    input  wire logic [7:0]      payload_xor,
    input  wire logic [7:0]      payload_byte,
    input  wire logic            final_byte,
    input  wire logic            sequence_bit,
    output ifsf_pkg::burst_t     burst,
    output logic                 inside_next,
    output logic [7:0]           xor_next
);

    logic [7:0]                      ctrl;
    logic [7:0]                      xor_sum;
    logic [ifsf_pkg::BURST_W-1:0]    pos;

    // control byte and running check
    assign ctrl    = sequence_bit ? ifsf_pkg::CTRL_SEQ1 : ifsf_pkg::CTRL_SEQ0;
    assign xor_sum = (inside_frame ? payload_xor : 8'h00) ^ payload_byte;

    // pack the burst in line order
    always_comb
    begin
        burst       = '0;
        pos         = '0;
        if (!inside_frame)
        begin
            burst.bytes[0] = ifsf_pkg::FLAG_BYTE;
            burst.bytes[1] = station_address;
            burst.bytes[2] = ctrl;
            burst.bytes[3] = station_address ^ ctrl;
            pos            = ifsf_pkg::BURST_W'(4);
        end
        if (ifsf_pkg::needs_stuff(payload_byte))
        begin
            burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = ifsf_pkg::ESC_BYTE;
            pos = pos + 1'b1;
            burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = payload_byte ^ ifsf_pkg::STUFF_MASK;
        end
        else
        begin
            burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = payload_byte;
        end
        pos = pos + 1'b1;
        if (final_byte)
        begin
            if (ifsf_pkg::needs_stuff(xor_sum))
            begin
                burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = ifsf_pkg::ESC_BYTE;
                pos = pos + 1'b1;
                burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = xor_sum ^ ifsf_pkg::STUFF_MASK;
            end
            else
            begin
                burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = xor_sum;
            end
            pos = pos + 1'b1;
            burst.bytes[pos[ifsf_pkg::SLOT_W-1:0]] = ifsf_pkg::FLAG_BYTE;
            pos = pos + 1'b1;
        end
        burst.count  = pos;
        burst.closes = final_byte;
    end

    // frame state after this byte
    assign inside_next = !final_byte;
    assign xor_next    = final_byte ? 8'h00 : xor_sum;

endmodule
`default_nettype wire

/* src/info_frame_stuffing_framer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer
// Builds stuffed information frames (flag, address, control, BCC1, payload,
// BCC2, flag) from a stream of payload bytes, one line byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Each payload byte becomes a burst of 1 to 9 line bytes (4 header bytes on
// the first byte of a frame, 1 or 2 for the stuffed byte, and on the final
// byte 1 or 2 for BCC2 plus the closing flag). The burst is built in the
// cycle the byte is taken and held in a burst register; the output register
// sends one line byte per cycle while out_stall is low, so a payload byte
// holds the block until its line bytes (1 mid-frame, 2 stuffed, up to 9) go.
// The next payload byte is taken in the cycle the last byte of the current
// burst moves to the output register, so the line runs without gaps.
// station_address lies at byte address 0 and is used from the next header on.
module info_frame_stuffing_framer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ifsf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // payload byte input
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    payload_byte,
    input  wire logic                          final_byte,
    input  wire logic                          sequence_bit,
    // line byte output
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [7:0]                    line_byte,
    output logic                               run_last,
    output logic                               frame_done
);

    logic [7:0]                       addr_reg;
    logic                             inside_reg;
    logic                             inside_next;
    logic [7:0]                       xor_reg;
    logic [7:0]                       xor_next;
    ifsf_pkg::burst_t                 burst_reg;
    ifsf_pkg::burst_t                 burst_next;
    logic                             burst_valid_reg;
    logic [ifsf_pkg::BURST_W-1:0]     idx_reg;
    logic                             out_valid_reg;
    logic [7:0]                       out_byte_reg;
    logic                             out_last_reg;
    logic                             out_done_reg;
    logic                             cfg_write;
    logic                             in_xfer;
    logic                             out_free;
    logic                             emit;
    logic                             burst_end;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == ifsf_pkg::ADDR_STATION) ? {24'h0, addr_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ifsf_pkg::STATION_RESET;
        end
        else if (cfg_write && (paddr == ifsf_pkg::ADDR_STATION))
        begin
            addr_reg <= pwdata[7:0];
        end
    end

    // burst builder
    ifsf_burst u_burst
    (
        .station_address (addr_reg),
        .inside_frame    (inside_reg),
        .payload_xor     (xor_reg),
        .payload_byte    (payload_byte),
        .final_byte      (final_byte),
        .sequence_bit    (sequence_bit),
        .burst           (burst_next),
        .inside_next     (inside_next),
        .xor_next        (xor_next)
    );

    // handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = burst_valid_reg && out_free;
    assign burst_end = (idx_reg == burst_reg.count - 1'b1);
    assign in_stall  = burst_valid_reg && !(out_free && burst_end);
    assign in_xfer   = in_valid && !in_stall;

    // frame state and burst register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg      <= 1'b0;
            xor_reg         <= 8'h00;
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else if (in_xfer)
        begin
            inside_reg      <= inside_next;
            xor_reg         <= xor_next;
            burst_valid_reg <= 1'b1;
            idx_reg         <= '0;
        end
        else if (emit)
        begin
            if (burst_end)
            begin
                burst_valid_reg <= 1'b0;
                idx_reg         <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            burst_reg <= burst_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= burst_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= burst_reg.bytes[idx_reg[ifsf_pkg::SLOT_W-1:0]];
            out_last_reg <= burst_end;
            out_done_reg <= burst_end && burst_reg.closes;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_byte  = out_byte_reg;
    assign run_last   = out_last_reg;
    assign frame_done = out_done_reg;

endmodule
`default_nettype wire

/* src/ifsf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsf_checker
// Port-level checks of the framer output channel, bound to the top level.
// ----------------------------------------------------------------------------
module ifsf_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] line_byte,
    input  wire logic       run_last,
    input  wire logic       frame_done
);

    // closing flag ends the burst of its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> run_last)
        else $error("closing flag not marked last");

    // closing flag carries the flag code
    a_done_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> line_byte == ifsf_pkg::FLAG_BYTE)
        else $error("closing byte is not a flag");

    // stalled output stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped under stall");

    // stalled output payload holds
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(line_byte) && $stable(run_last)
            && $stable(frame_done))
        else $error("output payload changed under stall");

endmodule

bind info_frame_stuffing_framer ifsf_checker u_ifsf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_byte  (line_byte),
    .run_last   (run_last),
    .frame_done (frame_done)
);
`default_nettype wire
